// ===== hdl/dqts_pkg.sv =====
// dqts_pkg: shared types and constants for the dual quadrature time setter
// no dependencies; used by dual_quadrature_time_setter_top
package dqts_pkg;

   localparam int HOURS_W   = 4;
   localparam int MINUTES_W = 6;
   localparam int HHMM_W    = 11;
   localparam int STEPS_W   = 3;

   localparam int STEP_LIMIT       = 3;
   localparam int MINUTE_MAX       = 59;
   localparam int MINUTES_PER_HOUR = 60;
   localparam int HOUR_MIN         = 1;
   localparam int HOUR_MAX         = 12;
   localparam logic [HHMM_W-1:0] HHMM_SCALE = 11'd100;

   typedef enum logic [0:0] {
      OP_TICK   = 1'b0,
      OP_PRESET = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_01     = 4'b0010,
      PH_DETENT = 4'b0100,
      PH_10     = 4'b1000
   } phase_type;

   typedef struct packed {
      op_type                 operation;
      logic                   enc1_pin_a;
      logic                   enc1_pin_b;
      logic                   enc2_pin_a;
      logic                   enc2_pin_b;
      logic [HOURS_W-1:0]     preset_hours;
      logic [MINUTES_W-1:0]   preset_minutes;
   } req_type;

   typedef struct packed {
      logic [HOURS_W-1:0]     hours_out;
      logic [MINUTES_W-1:0]   minutes_out;
      logic [HHMM_W-1:0]      hhmm_out;
   } rsp_type;

   // per-encoder walk state, prev_ab holds a in bit 0 and b in bit 1
   typedef struct packed {
      phase_type                  phase;
      logic signed [STEPS_W-1:0]  steps;
      logic [1:0]                 prev_ab;
   } enc_type;

   typedef struct packed {
      enc_type            nxt;
      logic signed [1:0]  delta;
   } walk_type;

endpackage

// ===== hdl/dual_quadrature_time_setter_top.sv =====
// dual_quadrature_time_setter_top: two quadrature knobs that set hours and minutes
// depends on dqts_pkg for the beat structs, walk state type and constants
//
//   port group   dir   payload               notes
//   req_*        in    dqts_pkg::req_type    tick with pin levels or preset
//   rsp_*        out   dqts_pkg::rsp_type    one beat per req beat
//
// one req beat per cycle sustained while rsp_stall is low
// the walk and the time wrap sit between the input register and the result register
// reset is synchronous: encoders go idle with prev pins high, held time zero
// rsp_stall holds the result register; req_stall = both stages full && rsp_stall
module dual_quadrature_time_setter_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dqts_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dqts_pkg::rsp_type rsp_payload
);

   function automatic dqts_pkg::walk_type walk(dqts_pkg::enc_type st, logic a, logic b);
      dqts_pkg::walk_type res;
      logic               oa;
      logic               ob;
      logic signed [3:0]  cnt;
      oa        = st.prev_ab[0];
      ob        = st.prev_ab[1];
      cnt       = {st.steps[dqts_pkg::STEPS_W-1], st.steps};
      res.nxt   = st;
      res.delta = 2'sd0;
      unique case (st.phase)
         dqts_pkg::PH_IDLE: begin
            if (cnt == 4'(dqts_pkg::STEP_LIMIT)) begin
               res.delta = 2'sd1;
            end else if (cnt == -4'(dqts_pkg::STEP_LIMIT)) begin
               res.delta = -2'sd1;
            end
            cnt = 4'sd0;
            if ({b, a} != st.prev_ab) begin
               if (!a && b) begin
                  if (oa) begin
                     res.nxt.phase = dqts_pkg::PH_01;
                     cnt = cnt + 4'sd1;
                  end
               end else if (a && !b) begin
                  if (ob) begin
                     res.nxt.phase = dqts_pkg::PH_10;
                     cnt = cnt - 4'sd1;
                  end
               end
            end
         end
         dqts_pkg::PH_01: begin
            if (!a && !b) begin
               if (ob) begin
                  res.nxt.phase = dqts_pkg::PH_DETENT;
                  cnt = cnt + 4'sd1;
               end
            end else if (a && b) begin
               if (!oa) res.nxt.phase = dqts_pkg::PH_IDLE;
            end
         end
         dqts_pkg::PH_DETENT: begin
            if (a && !b) begin
               if (!oa) begin
                  res.nxt.phase = dqts_pkg::PH_10;
                  cnt = cnt + 4'sd1;
               end
            end else if (!a && b) begin
               if (!ob) begin
                  res.nxt.phase = dqts_pkg::PH_01;
                  cnt = cnt - 4'sd1;
               end
            end
         end
         dqts_pkg::PH_10: begin
            if (a && b) begin
               if (!ob) res.nxt.phase = dqts_pkg::PH_IDLE;
            end else if (!a && !b) begin
               if (oa) begin
                  res.nxt.phase = dqts_pkg::PH_DETENT;
                  cnt = cnt - 4'sd1;
               end
            end
         end
         default: begin
            res.nxt.phase = st.phase;
         end
      endcase
      if (cnt > 4'(dqts_pkg::STEP_LIMIT)) cnt = 4'(dqts_pkg::STEP_LIMIT);
      if (cnt < -4'(dqts_pkg::STEP_LIMIT)) cnt = -4'(dqts_pkg::STEP_LIMIT);
      res.nxt.steps   = cnt[dqts_pkg::STEPS_W-1:0];
      res.nxt.prev_ab = {b, a};
      return res;
   endfunction

   localparam dqts_pkg::enc_type ENC_RESET = '{
      phase:   dqts_pkg::PH_IDLE,
      steps:   '0,
      prev_ab: 2'b11
   };

   logic                                 s1_valid_ff, s1_valid_in;
   dqts_pkg::req_type                    s1_data_ff;
   logic                                 out_valid_ff, out_valid_in;
   dqts_pkg::rsp_type                    out_data_ff, out_data_in;
   dqts_pkg::enc_type                    enc1_ff, enc1_in;
   dqts_pkg::enc_type                    enc2_ff, enc2_in;
   logic [dqts_pkg::HOURS_W-1:0]         hours_ff, hours_in;
   logic [dqts_pkg::MINUTES_W-1:0]       minutes_ff, minutes_in;

   logic                                 s1_move;
   logic                                 req_take;
   dqts_pkg::walk_type                   walk1;
   dqts_pkg::walk_type                   walk2;
   logic signed [5:0]                    h_sum;
   logic signed [7:0]                    m_sum;

   assign s1_move   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && rsp_stall);

   always_comb begin
      walk1 = walk(enc1_ff, s1_data_ff.enc1_pin_a, s1_data_ff.enc1_pin_b);
      walk2 = walk(enc2_ff, s1_data_ff.enc2_pin_a, s1_data_ff.enc2_pin_b);
      enc1_in = enc1_ff;
      enc2_in = enc2_ff;
      if (s1_data_ff.operation == dqts_pkg::OP_PRESET) begin
         h_sum = {2'b00, s1_data_ff.preset_hours};
         m_sum = {2'b00, s1_data_ff.preset_minutes};
      end else begin
         enc1_in = walk1.nxt;
         enc2_in = walk2.nxt;
         h_sum = 6'({2'b00, hours_ff}) + 6'(walk1.delta);
         m_sum = 8'({2'b00, minutes_ff}) + 8'(walk2.delta);
      end
      // minute carry and borrow, then hour wrap
      if (m_sum > 8'(dqts_pkg::MINUTE_MAX)) begin
         h_sum = h_sum + 6'sd1;
         m_sum = m_sum - 8'(dqts_pkg::MINUTES_PER_HOUR);
      end else if (m_sum < 8'sd0) begin
         h_sum = h_sum - 6'sd1;
         m_sum = 8'(dqts_pkg::MINUTE_MAX);
      end
      if (h_sum > 6'(dqts_pkg::HOUR_MAX)) begin
         h_sum = 6'(dqts_pkg::HOUR_MIN);
      end else if (h_sum < 6'(dqts_pkg::HOUR_MIN)) begin
         h_sum = 6'(dqts_pkg::HOUR_MAX);
      end
      hours_in                = h_sum[dqts_pkg::HOURS_W-1:0];
      minutes_in              = m_sum[dqts_pkg::MINUTES_W-1:0];
      out_data_in.hours_out   = hours_in;
      out_data_in.minutes_out = minutes_in;
      out_data_in.hhmm_out    = {7'd0, hours_in} * dqts_pkg::HHMM_SCALE
                                + {5'd0, minutes_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         enc1_ff      <= ENC_RESET;
         enc2_ff      <= ENC_RESET;
         hours_ff     <= '0;
         minutes_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_move) begin
            enc1_ff    <= enc1_in;
            enc2_ff    <= enc2_in;
            hours_ff   <= hours_in;
            minutes_ff <= minutes_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) s1_data_ff <= req_payload;
      if (s1_move) out_data_ff <= out_data_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   a_hours_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.hours_out >= 4'(dqts_pkg::HOUR_MIN)
                     && rsp_payload.hours_out <= 4'(dqts_pkg::HOUR_MAX)))
      else $error("hours out of range");

   a_minutes_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.minutes_out <= 6'(dqts_pkg::MINUTE_MAX))
      else $error("minutes out of range");

   a_hhmm_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.hhmm_out == {7'd0, rsp_payload.hours_out}
         * dqts_pkg::HHMM_SCALE + {5'd0, rsp_payload.minutes_out})
      else $error("hhmm mismatch");

   a_steps_range: assert property (@(posedge clock) disable iff (reset)
      enc1_ff.steps != -3'sd4 && enc2_ff.steps != -3'sd4)
      else $error("step count out of range");

   a_held_matches_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> (rsp_payload.hours_out == hours_ff
                   && rsp_payload.minutes_out == minutes_ff))
      else $error("result differs from held time");

endmodule
